### hdl/tldm_pkg.sv
// ============================================================================
// tldm_pkg
// Shared widths, codes and types of the three-level direct-mapped cache core.
// ============================================================================
`default_nettype none

package tldm_pkg;

    // Field widths of the request, response and configuration channels
    localparam int BLOCK_ADDRESS_BITS = 16;
    localparam int HIT_LEVEL_BITS     = 2;
    localparam int ACCESS_COST_BITS   = 10;
    localparam int COST_BITS          = 8;
    localparam int CFG_INDEX_BITS     = 8;
    localparam int CFG_DATA_BITS      = 8;

    // Default geometry
    localparam int DEF_LEVEL_ONE_SETS   = 8;
    localparam int DEF_LEVEL_TWO_SETS   = 16;
    localparam int DEF_LEVEL_THREE_SETS = 32;
    localparam int DEF_ADDRESS_BITS     = 16;

    // Cost register values after reset
    localparam logic [COST_BITS-1:0] COST_LEVEL_ONE_RESET   = 8'd1;
    localparam logic [COST_BITS-1:0] COST_LEVEL_TWO_RESET   = 8'd10;
    localparam logic [COST_BITS-1:0] COST_LEVEL_THREE_RESET = 8'd100;
    localparam logic [COST_BITS-1:0] COST_MAIN_MEMORY_RESET = 8'd200;

    // Where a request was found
    typedef enum logic [HIT_LEVEL_BITS-1:0] {
        HIT_LEVEL_ONE   = 2'd0,
        HIT_LEVEL_TWO   = 2'd1,
        HIT_LEVEL_THREE = 2'd2,
        HIT_MAIN_MEMORY = 2'd3
    } hit_level_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COST_LEVEL_ONE   = 8'd0,
        CFG_COST_LEVEL_TWO   = 8'd1,
        CFG_COST_LEVEL_THREE = 8'd2,
        CFG_COST_MAIN_MEMORY = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COST_BITS-1:0] level_one;
        logic [COST_BITS-1:0] level_two;
        logic [COST_BITS-1:0] level_three;
        logic [COST_BITS-1:0] main_memory;
    } cost_set_t;

    typedef struct packed {
        hit_level_t                  hit_level;
        logic [ACCESS_COST_BITS-1:0] access_cost;
    } lookup_result_t;

endpackage

`default_nettype wire

### hdl/tldm_if.sv
// ============================================================================
// tldm_if
// Valid/ready channel interfaces: request, response and configuration write.
// ============================================================================
`default_nettype none

interface tldm_req_if
    import tldm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [BLOCK_ADDRESS_BITS-1:0] block_address;

    modport source (output valid, output block_address, input ready);
    modport sink   (input valid, input block_address, output ready);
endinterface

interface tldm_rsp_if
    import tldm_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [HIT_LEVEL_BITS-1:0]   hit_level;
    logic [ACCESS_COST_BITS-1:0] access_cost;

    modport source (output valid, output hit_level, output access_cost, input ready);
    modport sink   (input valid, input hit_level, input access_cost, output ready);
endinterface

interface tldm_cfg_if
    import tldm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/tldm_cfg_regs.sv
// ============================================================================
// tldm_cfg_regs
// Cost registers of the four levels, written through the configuration port.
// ============================================================================
`default_nettype none

module tldm_cfg_regs
    import tldm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] wr_index,
    input  wire logic [CFG_DATA_BITS-1:0]  wr_data,
    output cost_set_t                      costs
);

    cost_set_t costs_reg;
    cost_set_t costs_next;

    // Decode the register index; drop writes to unknown indexes
    always_comb
    begin
        costs_next = costs_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_COST_LEVEL_ONE:   costs_next.level_one   = COST_BITS'(wr_data);
                CFG_COST_LEVEL_TWO:   costs_next.level_two   = COST_BITS'(wr_data);
                CFG_COST_LEVEL_THREE: costs_next.level_three = COST_BITS'(wr_data);
                CFG_COST_MAIN_MEMORY: costs_next.main_memory = COST_BITS'(wr_data);
                default:              costs_next = costs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            costs_reg.level_one   <= COST_LEVEL_ONE_RESET;
            costs_reg.level_two   <= COST_LEVEL_TWO_RESET;
            costs_reg.level_three <= COST_LEVEL_THREE_RESET;
            costs_reg.main_memory <= COST_MAIN_MEMORY_RESET;
        end
        else
        begin
            costs_reg <= costs_next;
        end
    end

    assign costs = costs_reg;

endmodule

`default_nettype wire

### hdl/tldm_slot_div.sv
// ============================================================================
// tldm_slot_div
// Two-stage set index unit: address modulo the set count of one level.
// ============================================================================
`default_nettype none

module tldm_slot_div
    import tldm_pkg::*;
#(
    parameter int SETS       = DEF_LEVEL_ONE_SETS,
    parameter int ADDR_WIDTH = DEF_ADDRESS_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  load_a,
    input  wire logic                  load_b,
    input  wire logic [ADDR_WIDTH-1:0] addr_a,
    input  wire logic [ADDR_WIDTH-1:0] addr_b,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] slot
);

    // Quotient by multiply-high with a rounded-up reciprocal; exact for every
    // address of ADDR_WIDTH bits since the rounding error stays below SETS.
    localparam int LOG_SETS  = $clog2(SETS);
    localparam int SLOT_BITS = (SETS > 1) ? LOG_SETS : 1;
    localparam int SHIFT     = ADDR_WIDTH + LOG_SETS;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(SETS) - 64'd1) / longint'(SETS);
    localparam int RECIP_BITS = ADDR_WIDTH + 1;
    localparam int PROD_BITS  = 2 * ADDR_WIDTH + 1 + LOG_SETS;
    localparam int BACK_BITS  = ADDR_WIDTH + LOG_SETS + 1;

    localparam logic [RECIP_BITS-1:0] RECIP_VALUE = RECIP_BITS'(RECIP);

    logic [ADDR_WIDTH-1:0] quot_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [PROD_BITS-1:0]  prod;
    logic [PROD_BITS-1:0]  prod_shift;
    logic [BACK_BITS-1:0]  back_prod;
    logic [ADDR_WIDTH-1:0] rem;

    // Stage A: quotient estimate
    assign prod       = PROD_BITS'(addr_a) * PROD_BITS'(RECIP_VALUE);
    assign prod_shift = prod >> SHIFT;

    // Stage B: remainder from the registered quotient
    assign back_prod = BACK_BITS'(quot_reg) * BACK_BITS'(SETS);
    assign rem       = addr_b - back_prod[ADDR_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            quot_reg <= prod_shift[ADDR_WIDTH-1:0];
        end
        if (load_b)
        begin
            slot_reg <= SLOT_BITS'(rem);
        end
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

### hdl/tldm_lookup.sv
// ============================================================================
// tldm_lookup
// Tag store of the three levels: probe, hit level, cost sum and line swaps.
// ============================================================================
`default_nettype none

module tldm_lookup
    import tldm_pkg::*;
#(
    parameter int LEVEL_ONE_SETS   = DEF_LEVEL_ONE_SETS,
    parameter int LEVEL_TWO_SETS   = DEF_LEVEL_TWO_SETS,
    parameter int LEVEL_THREE_SETS = DEF_LEVEL_THREE_SETS,
    parameter int ADDR_WIDTH       = DEF_ADDRESS_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  commit,
    input  wire logic [ADDR_WIDTH-1:0] addr,
    input  wire logic [((LEVEL_ONE_SETS > 1) ? $clog2(LEVEL_ONE_SETS) : 1)-1:0]     slot1,
    input  wire logic [((LEVEL_TWO_SETS > 1) ? $clog2(LEVEL_TWO_SETS) : 1)-1:0]     slot2,
    input  wire logic [((LEVEL_THREE_SETS > 1) ? $clog2(LEVEL_THREE_SETS) : 1)-1:0] slot3,
    input  wire cost_set_t             costs,
    output lookup_result_t             result
);

    logic                  l1_valid_reg [LEVEL_ONE_SETS];
    logic [ADDR_WIDTH-1:0] l1_addr_reg  [LEVEL_ONE_SETS];
    logic                  l2_valid_reg [LEVEL_TWO_SETS];
    logic [ADDR_WIDTH-1:0] l2_addr_reg  [LEVEL_TWO_SETS];
    logic                  l3_valid_reg [LEVEL_THREE_SETS];
    logic [ADDR_WIDTH-1:0] l3_addr_reg  [LEVEL_THREE_SETS];

    logic                  l1_valid;
    logic [ADDR_WIDTH-1:0] l1_addr;
    logic                  l2_valid;
    logic [ADDR_WIDTH-1:0] l2_addr;
    logic                  hit1;
    logic                  hit2;
    logic                  hit3;

    // Probe all three levels at once
    assign l1_valid = l1_valid_reg[slot1];
    assign l1_addr  = l1_addr_reg[slot1];
    assign l2_valid = l2_valid_reg[slot2];
    assign l2_addr  = l2_addr_reg[slot2];
    assign hit1     = l1_valid && (l1_addr == addr);
    assign hit2     = l2_valid && (l2_addr == addr);
    assign hit3     = l3_valid_reg[slot3] && (l3_addr_reg[slot3] == addr);

    // Pick the hit level and add up the cost of every level probed
    always_comb
    begin
        result.access_cost = ACCESS_COST_BITS'(costs.level_one);
        if (hit1)
        begin
            result.hit_level = HIT_LEVEL_ONE;
        end
        else if (hit2)
        begin
            result.hit_level   = HIT_LEVEL_TWO;
            result.access_cost = result.access_cost + ACCESS_COST_BITS'(costs.level_two);
        end
        else if (hit3)
        begin
            result.hit_level   = HIT_LEVEL_THREE;
            result.access_cost = result.access_cost + ACCESS_COST_BITS'(costs.level_two)
                                 + ACCESS_COST_BITS'(costs.level_three);
        end
        else
        begin
            result.hit_level   = HIT_MAIN_MEMORY;
            result.access_cost = result.access_cost + ACCESS_COST_BITS'(costs.level_two)
                                 + ACCESS_COST_BITS'(costs.level_three)
                                 + ACCESS_COST_BITS'(costs.main_memory);
        end
    end

    // Move the block to level one, old level one down to level two and, when
    // level two missed, old level two down to level three
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVEL_ONE_SETS; i++)
            begin
                l1_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < LEVEL_TWO_SETS; i++)
            begin
                l2_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < LEVEL_THREE_SETS; i++)
            begin
                l3_valid_reg[i] <= 1'b0;
            end
        end
        else if (commit && !hit1)
        begin
            l1_valid_reg[slot1] <= 1'b1;
            l2_valid_reg[slot2] <= l1_valid;
            if (!hit2)
            begin
                l3_valid_reg[slot3] <= l2_valid;
            end
        end
    end

    // Line addresses carry no reset: an invalid line never hits
    always_ff @(posedge clk)
    begin
        if (commit && !hit1)
        begin
            l1_addr_reg[slot1] <= addr;
            l2_addr_reg[slot2] <= l1_addr;
            if (!hit2)
            begin
                l3_addr_reg[slot3] <= l2_addr;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/three_level_direct_mapped_cache_core.sv
// ============================================================================
// three_level_direct_mapped_cache_core
// Exclusive three-level direct-mapped tag cache with per-level access costs.
// ============================================================================
//
//  Channel | Dir | Payload                       | Accepted when
//  --------+-----+-------------------------------+---------------------
//  req     | in  | block_address[15:0]           | req.valid & req.ready
//  rsp     | out | hit_level[1:0], access_cost   | rsp.valid & rsp.ready
//  cfg     | in  | index[7:0], data[7:0]         | cfg.valid & cfg.ready
//
//  One request per cycle sustained while responses are taken; the quotient
//  estimate runs on the incoming address, the remainder is then computed from
//  the registered quotient, and probe, swap and cost sum are registered into
//  the response register that drives rsp.valid.
//  Reset clears all line valid bits and loads the default costs at once.
//  A stalled response holds the last stage; earlier stages keep filling.
//  cfg.ready is always high.
// ============================================================================
`default_nettype none

module three_level_direct_mapped_cache_core
    import tldm_pkg::*;
#(
    parameter int LEVEL_ONE_SETS   = DEF_LEVEL_ONE_SETS,
    parameter int LEVEL_TWO_SETS   = DEF_LEVEL_TWO_SETS,
    parameter int LEVEL_THREE_SETS = DEF_LEVEL_THREE_SETS,
    parameter int ADDRESS_BITS     = DEF_ADDRESS_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tldm_req_if.sink  req,
    tldm_rsp_if.source rsp,
    tldm_cfg_if.sink  cfg
);

    localparam int AW = (ADDRESS_BITS < BLOCK_ADDRESS_BITS) ? ADDRESS_BITS
                                                             : BLOCK_ADDRESS_BITS;
    localparam int S1_BITS = (LEVEL_ONE_SETS > 1) ? $clog2(LEVEL_ONE_SETS) : 1;
    localparam int S2_BITS = (LEVEL_TWO_SETS > 1) ? $clog2(LEVEL_TWO_SETS) : 1;
    localparam int S3_BITS = (LEVEL_THREE_SETS > 1) ? $clog2(LEVEL_THREE_SETS) : 1;

    logic           s1_valid_reg;
    logic           s2_valid_reg;
    logic           rsp_valid_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic [AW-1:0]  s2_addr_reg;
    lookup_result_t rsp_result_reg;

    logic           out_ready;
    logic           s2_ready;
    logic           s1_ready;
    logic           load_s1;
    logic           load_s2;
    logic           commit;
    logic [AW-1:0]  in_addr;
    logic [S1_BITS-1:0] slot1;
    logic [S2_BITS-1:0] slot2;
    logic [S3_BITS-1:0] slot3;
    cost_set_t      costs;
    lookup_result_t lookup_result;

    // Stage handshakes: a stage advances when the next one is empty or moving
    assign out_ready = !rsp_valid_reg || rsp.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign load_s1   = req.valid && s1_ready;
    assign load_s2   = s1_valid_reg && s2_ready;
    assign commit    = s2_valid_reg && out_ready;
    assign req.ready = s1_ready;
    assign in_addr   = req.block_address[AW-1:0];

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    tldm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .costs    (costs)
    );

    tldm_slot_div #(.SETS(LEVEL_ONE_SETS), .ADDR_WIDTH(AW)) u_slot1 (
        .clk    (clk),
        .load_a (load_s1),
        .load_b (load_s2),
        .addr_a (in_addr),
        .addr_b (s1_addr_reg),
        .slot   (slot1)
    );

    tldm_slot_div #(.SETS(LEVEL_TWO_SETS), .ADDR_WIDTH(AW)) u_slot2 (
        .clk    (clk),
        .load_a (load_s1),
        .load_b (load_s2),
        .addr_a (in_addr),
        .addr_b (s1_addr_reg),
        .slot   (slot2)
    );

    tldm_slot_div #(.SETS(LEVEL_THREE_SETS), .ADDR_WIDTH(AW)) u_slot3 (
        .clk    (clk),
        .load_a (load_s1),
        .load_b (load_s2),
        .addr_a (in_addr),
        .addr_b (s1_addr_reg),
        .slot   (slot3)
    );

    tldm_lookup #(
        .LEVEL_ONE_SETS   (LEVEL_ONE_SETS),
        .LEVEL_TWO_SETS   (LEVEL_TWO_SETS),
        .LEVEL_THREE_SETS (LEVEL_THREE_SETS),
        .ADDR_WIDTH       (AW)
    ) u_lookup (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .addr   (s2_addr_reg),
        .slot1  (slot1),
        .slot2  (slot2),
        .slot3  (slot3),
        .costs  (costs),
        .result (lookup_result)
    );

    // Advance the stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                rsp_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Carry the address along and capture the response
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_addr_reg <= in_addr;
        end
        if (load_s2)
        begin
            s2_addr_reg <= s1_addr_reg;
        end
        if (commit)
        begin
            rsp_result_reg <= lookup_result;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit_level   = rsp_result_reg.hit_level;
    assign rsp.access_cost = rsp_result_reg.access_cost;

endmodule

`default_nettype wire

### hdl/tldm_checker.sv
// ============================================================================
// tldm_checker
// Port-level checks of the cache core, bound to the top level.
// ============================================================================
`default_nettype none

module tldm_checker
    import tldm_pkg::*;
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [HIT_LEVEL_BITS-1:0]   hit_level,
    input wire logic [ACCESS_COST_BITS-1:0] access_cost
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_level) && $stable(access_cost))
        else $error("stalled response changed or dropped");

    // A level one hit only pays for the level one probe
    a_l1_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (hit_level == HIT_LEVEL_ONE) |-> access_cost <= 10'd255)
        else $error("level one hit with cost above one probe");

    // Without a memory read at most three probes are paid
    a_cache_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (hit_level != HIT_MAIN_MEMORY) |-> access_cost <= 10'd765)
        else $error("cache hit with cost above three probes");

    // A response that appears from an empty output traces back to an accepted request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
        else $error("response without a request three cycles earlier");

endmodule

bind three_level_direct_mapped_cache_core tldm_checker u_tldm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .hit_level   (rsp.hit_level),
    .access_cost (rsp.access_cost)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Checks the three-level direct-mapped cache core against a tag predictor.
// Lookup requests run with bursty traffic while responses back-pressure at
// random. Each response is checked against a local model of the three tag
// levels and the cost registers. A directed set of lookups comes first. Then
// several phases of random lookups follow, each under its own cost setting.
// ============================================================================

module tb;
    import tldm_pkg::*;

    localparam int PIPE_LATENCY     = 3;
    localparam int LIMIT_CYCLES     = 300000;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 216;
    localparam int POOL_SIZE        = 40;
    localparam int MAX_REPORTS      = 40;
    localparam int DIRECTED_ROWS    = 24;

    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_FIRST_UNUSED = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_LAST         = 8'hFF;

    typedef logic [BLOCK_ADDRESS_BITS-1:0] block_addr_t;

    typedef struct {
        bit          valid;
        block_addr_t addr;
    } tag_line_t;

    typedef struct {
        block_addr_t                 addr;
        bit                          fixed;
        hit_level_t                  level;
        logic [ACCESS_COST_BITS-1:0] cost;
    } directed_row_t;

    typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

    logic clk;
    logic rst_n;

    tldm_req_if req_ch ();
    tldm_rsp_if rsp_ch ();
    tldm_cfg_if cfg_ch ();

    three_level_direct_mapped_cache_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predictor copy of the tag levels and cost registers
    tag_line_t      l1_tags [DEF_LEVEL_ONE_SETS];
    tag_line_t      l2_tags [DEF_LEVEL_TWO_SETS];
    tag_line_t      l3_tags [DEF_LEVEL_THREE_SETS];
    cost_set_t      costs;
    lookup_result_t pending_lookups [$];

    block_addr_t addr_pool [POOL_SIZE];
    block_addr_t last_addr   = '0;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;

    // Sets 0..2 are fresh for the hit and eviction sequences below
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, HIT_MAIN_MEMORY, 10'd311},  // zero address, line invalid
        '{16'h0000, 1'b1, HIT_LEVEL_ONE,   10'd1},
        '{16'hFFFF, 1'b1, HIT_MAIN_MEMORY, 10'd311},
        '{16'hFFFF, 1'b1, HIT_LEVEL_ONE,   10'd1},
        '{16'h0001, 1'b1, HIT_MAIN_MEMORY, 10'd311},
        '{16'h0011, 1'b1, HIT_MAIN_MEMORY, 10'd311},
        '{16'h0001, 1'b1, HIT_LEVEL_TWO,   10'd11},
        '{16'h0011, 1'b1, HIT_LEVEL_TWO,   10'd11},
        '{16'h0002, 1'b1, HIT_MAIN_MEMORY, 10'd311},
        '{16'h0022, 1'b1, HIT_MAIN_MEMORY, 10'd311},
        '{16'h0042, 1'b1, HIT_MAIN_MEMORY, 10'd311},
        '{16'h0002, 1'b1, HIT_LEVEL_THREE, 10'd111},
        '{16'h0022, 1'b1, HIT_LEVEL_THREE, 10'd111},
        '{16'h0042, 1'b1, HIT_LEVEL_THREE, 10'd111},
        '{16'h0062, 1'b1, HIT_MAIN_MEMORY, 10'd311},  // evicts 0x0002 from level three
        '{16'h0002, 1'b1, HIT_MAIN_MEMORY, 10'd311},  // evicted line is gone
        '{16'h0008, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'h0010, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'h0008, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'h8000, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'h7FFF, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'h5555, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'hAAAA, 1'b0, HIT_LEVEL_ONE,   10'd0},
        '{16'h0000, 1'b0, HIT_LEVEL_ONE,   10'd0}
    };

    // Clear all tag lines and load the default costs
    function automatic void clear_cache_model();
        foreach (l1_tags[i]) l1_tags[i] = '{1'b0, '0};
        foreach (l2_tags[i]) l2_tags[i] = '{1'b0, '0};
        foreach (l3_tags[i]) l3_tags[i] = '{1'b0, '0};
        costs.level_one   = COST_LEVEL_ONE_RESET;
        costs.level_two   = COST_LEVEL_TWO_RESET;
        costs.level_three = COST_LEVEL_THREE_RESET;
        costs.main_memory = COST_MAIN_MEMORY_RESET;
    endfunction

    // Probe the levels in order, move the block to level one, sum the costs
    function automatic lookup_result_t predict_lookup(block_addr_t addr);
        int             s1;
        int             s2;
        int             s3;
        tag_line_t      held;
        lookup_result_t res;
        s1 = addr % DEF_LEVEL_ONE_SETS;
        s2 = addr % DEF_LEVEL_TWO_SETS;
        s3 = addr % DEF_LEVEL_THREE_SETS;
        res.access_cost = ACCESS_COST_BITS'(costs.level_one);
        if (l1_tags[s1].valid && l1_tags[s1].addr == addr)
        begin
            res.hit_level = HIT_LEVEL_ONE;
        end
        else
        begin
            res.access_cost = res.access_cost + ACCESS_COST_BITS'(costs.level_two);
            if (l2_tags[s2].valid && l2_tags[s2].addr == addr)
            begin
                res.hit_level = HIT_LEVEL_TWO;
                held        = l1_tags[s1];
                l1_tags[s1] = l2_tags[s2];
                l2_tags[s2] = held;
            end
            else
            begin
                res.access_cost = res.access_cost + ACCESS_COST_BITS'(costs.level_three);
                if (l3_tags[s3].valid && l3_tags[s3].addr == addr)
                begin
                    res.hit_level = HIT_LEVEL_THREE;
                end
                else
                begin
                    res.access_cost = res.access_cost + ACCESS_COST_BITS'(costs.main_memory);
                    res.hit_level   = HIT_MAIN_MEMORY;
                    l3_tags[s3]     = '{1'b1, addr};
                end
                held        = l2_tags[s2];
                l2_tags[s2] = l3_tags[s3];
                l3_tags[s3] = held;
                held        = l1_tags[s1];
                l1_tags[s1] = l2_tags[s2];
                l2_tags[s2] = held;
            end
        end
        return res;
    endfunction

    // Build a working set of blocks that collide in all three levels
    function automatic void refill_pool();
        logic [BLOCK_ADDRESS_BITS-6:0] uppers [3];
        foreach (uppers[i]) uppers[i] = (BLOCK_ADDRESS_BITS-5)'($urandom);
        foreach (addr_pool[i]) addr_pool[i] = {uppers[$urandom_range(0, 2)], 5'($urandom)};
    endfunction

    // Mostly the working set, some repeats, some noise over the whole space
    function automatic block_addr_t next_address();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            last_addr = block_addr_t'($urandom);
        else if (pick >= 25)
            last_addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return last_addr;
    endfunction

    // Offer one lookup request, record its expectation, pace the bursts
    task automatic send_request(input block_addr_t addr, input bit fixed,
                                input lookup_result_t fixed_result);
        lookup_result_t predicted;
        int             gap;
        req_ch.valid         <= 1'b1;
        req_ch.block_address <= addr;
        do @(posedge clk); while (!req_ch.ready);
        predicted = predict_lookup(addr);
        pending_lookups.push_back(fixed ? fixed_result : predicted);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 9);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (index)
            CFG_COST_LEVEL_ONE:   costs.level_one   = data;
            CFG_COST_LEVEL_TWO:   costs.level_two   = data;
            CFG_COST_LEVEL_THREE: costs.level_three = data;
            CFG_COST_MAIN_MEMORY: costs.main_memory = data;
            default: ;
        endcase
    endtask

    // Hold requests until every response is back and the pipe is empty
    task automatic drain();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response stalls: open, light, heavy and periodic stretches
    initial
    begin
        sink_mode_t mode;
        int         stretch_left;
        rsp_ch.ready <= 1'b0;
        mode         = SINK_OPEN;
        stretch_left = 0;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                mode         = sink_mode_t'($urandom_range(0, 3));
                stretch_left = $urandom_range(5, 60);
            end
            stretch_left--;
            case (mode)
                SINK_OPEN:  rsp_ch.ready <= 1'b1;
                SINK_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default:    rsp_ch.ready <= (stretch_left % 3 != 0);
            endcase
        end
    end

    // Compare each response with the oldest expectation
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected response, expected none, actual level %0d cost %0d",
                             $time, rsp_ch.hit_level, rsp_ch.access_cost);
                fail_count++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.hit_level !== want.hit_level)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: hit_level mismatch, expected %0d, actual %0d",
                                 $time, want.hit_level, rsp_ch.hit_level);
                    fail_count++;
                end
                if (rsp_ch.access_cost !== want.access_cost)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: access_cost mismatch, expected %0d, actual %0d",
                                 $time, want.access_cost, rsp_ch.access_cost);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed lookups, then random phases
    initial
    begin
        lookup_result_t                fixed_result;
        cost_set_t                     phase_costs;
        logic [CFG_INDEX_BITS-1:0]     unused_index;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.block_address <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_COST_LEVEL_ONE;
        cfg_ch.data          <= '0;
        clear_cache_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lookups under the reset costs
        foreach (directed_rows[i])
        begin
            fixed_result.hit_level   = directed_rows[i].level;
            fixed_result.access_cost = directed_rows[i].cost;
            send_request(directed_rows[i].addr, directed_rows[i].fixed, fixed_result);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            // Program this phase's costs: all zero, all max, then random
            if (p == 0)
            begin
                phase_costs  = '0;
                unused_index = CFG_INDEX_FIRST_UNUSED;
            end
            else if (p == 1)
            begin
                phase_costs  = '1;
                unused_index = CFG_INDEX_LAST;
            end
            else
            begin
                phase_costs  = cost_set_t'($urandom);
                unused_index = CFG_INDEX_BITS'($urandom_range(CFG_INDEX_FIRST_UNUSED,
                                                              CFG_INDEX_LAST));
            end
            write_register(CFG_COST_LEVEL_ONE,   phase_costs.level_one);
            write_register(CFG_COST_LEVEL_TWO,   phase_costs.level_two);
            write_register(CFG_COST_LEVEL_THREE, phase_costs.level_three);
            write_register(CFG_COST_MAIN_MEMORY, phase_costs.main_memory);
            // An unused index must leave every cost alone
            write_register(unused_index, CFG_DATA_BITS'($urandom));
            cfg_ch.valid <= 1'b0;

            refill_pool();
            repeat (RANDOM_PER_PHASE) send_request(next_address(), 1'b0, fixed_result);
        end

        drain();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
